// ===== hw/rtl/pbg_pkg.sv =====
// phosphor ghosting blend: shared constants, register codes and decay tables
// no dependencies; used by the interfaces and every module of the block
`default_nettype none

package pbg_pkg;

  localparam int RGB_W      = 24;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 8;
  localparam int RGB565_W   = 16;
  localparam int MASK_W     = 4;
  localparam int CHAN_W     = 8;
  localparam int NUMER_W    = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;
  localparam int STRENGTH_W = 2;
  localparam int SCAN_W     = 2;
  localparam int WIDTH_W    = 10;
  localparam int HEIGHT_W   = 8;

  localparam int MAX_WIDTH_DEF  = 640;
  localparam int MAX_HEIGHT_DEF = 200;

  localparam logic [WIDTH_W-1:0]  ACT_WIDTH_RST  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] ACT_HEIGHT_RST = HEIGHT_W'(200);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRENGTH = 3'd0,
    CFG_SCANLINE = 3'd1,
    CFG_TALL     = 3'd2,
    CFG_WIDTH    = 3'd3,
    CFG_HEIGHT   = 3'd4
  } cfg_reg_t;

  localparam logic [RGB_W-1:0] MASK_LIT    = 24'hFCFCFC;
  localparam logic [RGB_W-1:0] MASK_BRIGHT = 24'h808080;
  localparam logic [RGB_W-1:0] MASK_KNEE   = 24'h202020;

  // decay numerators in 64ths, indexed by strength
  localparam logic [NUMER_W-1:0] NUMER_BRIGHT [4] = '{6'd0, 6'd14, 6'd18, 6'd24};
  localparam logic [NUMER_W-1:0] NUMER_KNEE   [4] = '{6'd0, 6'd40, 6'd48, 6'd56};
  localparam logic [NUMER_W-1:0] NUMER_TAIL   [4] = '{6'd0, 6'd58, 6'd60, 6'd61};

  function automatic logic [NUMER_W-1:0] pick_numer(
    input logic [RGB_W-1:0]      hist,
    input logic [STRENGTH_W-1:0] strength
  );
    logic [NUMER_W-1:0] n;
    if ((hist & MASK_LIT) == '0) begin
      n = '0;
    end else if ((hist & MASK_BRIGHT) != '0) begin
      n = NUMER_BRIGHT[strength];
    end else if ((hist & MASK_KNEE) != '0) begin
      n = NUMER_KNEE[strength];
    end else begin
      n = NUMER_TAIL[strength];
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pbg_in_if.sv =====
// source pixel channel: valid/ready handshake with pixel and position
// depends on pbg_pkg for field widths
`default_nettype none

interface pbg_in_if;
  logic                          valid;
  logic                          ready;
  logic [pbg_pkg::RGB_W-1:0]     pixel_rgb;
  logic [pbg_pkg::COL_W-1:0]     col;
  logic [pbg_pkg::ROW_W-1:0]     row;

  modport source (output valid, pixel_rgb, col, row, input ready);
  modport sink   (input valid, pixel_rgb, col, row, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pbg_out_if.sv =====
// result channel: valid/ready handshake with blended pixel, rgb565 and flags
// depends on pbg_pkg for field widths
`default_nettype none

interface pbg_out_if;
  logic                          valid;
  logic                          ready;
  logic [pbg_pkg::RGB_W-1:0]     blended_rgb;
  logic [pbg_pkg::RGB565_W-1:0]  rgb565;
  logic [pbg_pkg::MASK_W-1:0]    blank_mask;
  logic                          dropped;

  modport source (output valid, blended_rgb, rgb565, blank_mask, dropped, input ready);
  modport sink   (input valid, blended_rgb, rgb565, blank_mask, dropped, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pbg_history_ram.sv =====
// history store: one write port, one read port, registered read data
// depends on pbg_pkg for the pixel width
`default_nettype none

module pbg_history_ram #(
  parameter int DEPTH  = pbg_pkg::MAX_WIDTH_DEF * pbg_pkg::MAX_HEIGHT_DEF,
  parameter int ADDR_W = $clog2(pbg_pkg::MAX_WIDTH_DEF * pbg_pkg::MAX_HEIGHT_DEF)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [ADDR_W-1:0]         waddr,
  input  wire logic [pbg_pkg::RGB_W-1:0] wdata,
  input  wire logic                      re,
  input  wire logic [ADDR_W-1:0]         raddr,
  output      logic [pbg_pkg::RGB_W-1:0] rdata
);

  logic [pbg_pkg::RGB_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read during write to the same entry returns the old contents
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pbg_decay.sv =====
// decay datapath: scales a history pixel by its numerator, max with new pixel
// depends on pbg_pkg for widths and the numerator tables
`default_nettype none

module pbg_decay (
  input  wire logic [pbg_pkg::RGB_W-1:0]      hist_rgb,
  input  wire logic [pbg_pkg::RGB_W-1:0]      pixel_rgb,
  input  wire logic [pbg_pkg::STRENGTH_W-1:0] strength,
  output      logic [pbg_pkg::RGB_W-1:0]      res_rgb
);

  localparam int CW = pbg_pkg::CHAN_W;
  localparam int NW = pbg_pkg::NUMER_W;

  logic [NW-1:0] numer;

  assign numer = pbg_pkg::pick_numer(hist_rgb, strength);

  always_comb begin
    logic [CW+NW-1:0] prod;
    logic [CW-1:0]    scaled;
    logic [CW-1:0]    fresh;
    res_rgb = '0;
    for (int k = 0; k < 3; k++) begin
      prod   = (CW+NW)'(hist_rgb[k*CW +: CW]) * (CW+NW)'(numer);
      scaled = prod[CW+NW-1:NW];
      fresh  = pixel_rgb[k*CW +: CW];
      res_rgb[k*CW +: CW] = (fresh > scaled) ? fresh : scaled;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/phosphor_ghosting_blend.sv =====
// phosphor ghosting blend top level: config registers, history clear sweep,
// two-stage read-modify-write pipeline; depends on pbg_pkg, pbg_in_if,
// pbg_out_if, pbg_history_ram and pbg_decay
//
// usage
//   in_pix carries one source pixel with its column and row; out_pix returns
//   exactly one result per transfer, in order: the ghosted pixel in 8:8:8 and
//   rgb565, the scanline blank mask and the dropped flag
//   out_pix.valid rises once an input transfer has passed the read stage and
//   the output register; with the receiver ready and no clear sweep running,
//   the block takes one pixel every cycle, set by the single history read and
//   write-back done per pixel
//   the history memory has a registered read; a pixel hitting the entry that
//   the one ahead of it writes in the same cycle takes that value by forwarding
//   configuration writes are registered; writing strength, width or height
//   starts a clear sweep of all MAX_WIDTH * MAX_HEIGHT entries (128000 at the
//   defaults), during which in_pix.ready is low
//   after reset the same sweep runs before the first pixel is taken
//   when the receiver stalls, the output register holds its result and one
//   more pixel can still enter the read stage behind it
`default_nettype none

module phosphor_ghosting_blend #(
  parameter int MAX_WIDTH  = pbg_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = pbg_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pbg_in_if.sink                             in_pix,
  pbg_out_if.source                          out_pix,
  input  wire logic                          cfg_we,
  input  wire logic [pbg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pbg_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(MAX_WIDTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

  localparam int RGB_W = pbg_pkg::RGB_W;

  // configuration registers
  logic [pbg_pkg::STRENGTH_W-1:0] strength_r;
  logic [pbg_pkg::SCAN_W-1:0]     scan_mode_r;
  logic                           tall_r;
  logic [pbg_pkg::WIDTH_W-1:0]    act_w_r;
  logic [pbg_pkg::HEIGHT_W-1:0]   act_h_r;

  // clear sweep
  logic                clearing_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic                clr_start;

  // read stage (memory data returns here)
  logic                s1_valid_r;
  logic                s1_drop_r;
  logic                s1_ghost_r;
  logic                s1_fwd_r;
  logic [RGB_W-1:0]    s1_pix_r;
  logic [ADDR_W-1:0]   s1_addr_r;
  logic [RGB_W-1:0]    fwd_rgb_r;

  // output register
  logic                          out_valid_r;
  logic [RGB_W-1:0]              out_rgb_r;
  logic [pbg_pkg::RGB565_W-1:0]  out_565_r;
  logic [pbg_pkg::MASK_W-1:0]    out_mask_r;
  logic                          out_drop_r;

  // handshake and pipeline movement
  logic out_free, s1_move, s1_free, in_take;
  logic in_inwin, in_ghost, in_fwd;
  logic [ADDR_W-1:0] in_addr;

  // memory ports
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [RGB_W-1:0]  mem_wdata;
  logic [RGB_W-1:0]  mem_rdata;

  // datapath
  logic [RGB_W-1:0]             hist_rgb;
  logic [RGB_W-1:0]             decay_rgb;
  logic [RGB_W-1:0]             s1_res;
  logic [pbg_pkg::MASK_W-1:0]   blank_bits;

  assign out_free = !out_valid_r || out_pix.ready;
  assign s1_move  = s1_valid_r && out_free;
  assign s1_free  = !s1_valid_r || s1_move;

  assign in_pix.ready = s1_free && !clearing_r;
  assign in_take      = in_pix.valid && in_pix.ready;

  // window check against both the configured size and the store size
  assign in_inwin = (in_pix.col < act_w_r) && (32'(in_pix.col) < MAX_WIDTH) &&
                    (in_pix.row < act_h_r) && (32'(in_pix.row) < MAX_HEIGHT);
  assign in_ghost = in_inwin && (strength_r != '0);
  assign in_addr  = ADDR_W'(in_pix.row) * ROW_STRIDE + ADDR_W'(in_pix.col);

  // the pixel leaving the read stage writes this same entry on this edge
  assign in_fwd = s1_move && s1_ghost_r && (s1_addr_r == in_addr);

  assign clr_start = cfg_we &&
                     ((cfg_index == pbg_pkg::CFG_STRENGTH) ||
                      (cfg_index == pbg_pkg::CFG_WIDTH) ||
                      (cfg_index == pbg_pkg::CFG_HEIGHT));

  // the user must change config only when idle; the block does not enforce this
  always_comb begin
    if (clearing_r) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s1_move && s1_ghost_r;
      mem_waddr = s1_addr_r;
      mem_wdata = decay_rgb;
    end
  end

  pbg_history_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (in_take && in_ghost),
    .raddr (in_addr),
    .rdata (mem_rdata)
  );

  assign hist_rgb = s1_fwd_r ? fwd_rgb_r : mem_rdata;

  pbg_decay u_decay (
    .hist_rgb  (hist_rgb),
    .pixel_rgb (s1_pix_r),
    .strength  (strength_r),
    .res_rgb   (decay_rgb)
  );

  // strength off passes the pixel through untouched
  assign s1_res = s1_ghost_r ? decay_rgb : s1_pix_r;

  // blanked replica rows for the current vertical scale
  always_comb begin
    blank_bits = '0;
    if (tall_r) begin
      blank_bits[1] = (scan_mode_r >= 2'd3);
      blank_bits[2] = (scan_mode_r >= 2'd2);
      blank_bits[3] = (scan_mode_r >= 2'd1);
    end else begin
      blank_bits[1] = (scan_mode_r >= 2'd2);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r  <= '0;
      scan_mode_r <= '0;
      tall_r      <= 1'b1;
      act_w_r     <= pbg_pkg::ACT_WIDTH_RST;
      act_h_r     <= pbg_pkg::ACT_HEIGHT_RST;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pbg_pkg::CFG_STRENGTH: strength_r  <= cfg_data[pbg_pkg::STRENGTH_W-1:0];
          pbg_pkg::CFG_SCANLINE: scan_mode_r <= cfg_data[pbg_pkg::SCAN_W-1:0];
          pbg_pkg::CFG_TALL:     tall_r      <= cfg_data[0];
          pbg_pkg::CFG_WIDTH:    act_w_r     <= cfg_data[pbg_pkg::WIDTH_W-1:0];
          pbg_pkg::CFG_HEIGHT:   act_h_r     <= cfg_data[pbg_pkg::HEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (clr_start) begin
        clearing_r <= 1'b1;
        clr_cnt_r  <= '0;
      end else if (clearing_r) begin
        if (clr_cnt_r == LAST_ADDR) begin
          clearing_r <= 1'b0;
        end
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end

      if (s1_free) begin
        s1_valid_r <= in_take;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_drop_r  <= !in_inwin;
      s1_ghost_r <= in_ghost;
      s1_fwd_r   <= in_fwd;
      s1_pix_r   <= in_pix.pixel_rgb;
      s1_addr_r  <= in_addr;
      fwd_rgb_r  <= decay_rgb;
    end
    if (s1_move) begin
      out_drop_r <= s1_drop_r;
      out_rgb_r  <= s1_drop_r ? '0 : s1_res;
      out_565_r  <= s1_drop_r ? '0 : {s1_res[23:19], s1_res[15:10], s1_res[7:3]};
      out_mask_r <= s1_drop_r ? '0 : blank_bits;
    end
  end

  assign out_pix.valid       = out_valid_r;
  assign out_pix.blended_rgb = out_rgb_r;
  assign out_pix.rgb565      = out_565_r;
  assign out_pix.blank_mask  = out_mask_r;
  assign out_pix.dropped     = out_drop_r;

endmodule

`default_nettype wire
